// ===== hw/rtl/lsb_stego_payload_deframer_defines.svh =====
// Shared assertion macros for the stego deframer.
`ifndef LSB_STEGO_PAYLOAD_DEFRAMER_DEFINES_SVH
`define LSB_STEGO_PAYLOAD_DEFRAMER_DEFINES_SVH

// Check cons in the same cycle as ante.
`define LSPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lspd assertion failed");

// Check cons in the cycle after ante.
`define LSPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lspd assertion failed");

`endif

// ===== hw/rtl/lspd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lspd_pkg;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_MAGIC  = 3'd1,
    PH_EXTLEN = 3'd2,
    PH_EXTCHR = 3'd3,
    PH_SIZE   = 3'd4,
    PH_DATA   = 3'd5,
    PH_IDLE   = 3'd6
  } phase_t;

  localparam logic [2:0] SEC_MAGIC   = 3'd0;
  localparam logic [2:0] SEC_EXTLEN  = 3'd1;
  localparam logic [2:0] SEC_EXTCHR  = 3'd2;
  localparam logic [2:0] SEC_SIZE    = 3'd3;
  localparam logic [2:0] SEC_PAYLOAD = 3'd4;

  localparam logic [1:0] CFG_HEADER_LEN  = 2'd0;
  localparam logic [1:0] CFG_MAGIC_LEN   = 2'd1;
  localparam logic [1:0] CFG_MAGIC_VALUE = 2'd2;

  localparam logic [15:0] HEADER_LEN_RST  = 16'd54;
  localparam logic [3:0]  MAGIC_LEN_RST   = 4'd2;
  localparam logic [63:0] MAGIC_VALUE_RST = 64'h0000_0000_0000_2322;

endpackage

`default_nettype wire

// ===== hw/rtl/lsb_stego_payload_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "lsb_stego_payload_deframer_defines.svh"

// Extracts an LSB-hidden payload from a stream of image bytes. Each input transaction
// carries one byte and its frame-start flag; the first cfg header_len bytes of a frame are
// skipped, then bit 0 of every byte is shifted in MSB first to form the magic characters,
// the 32-bit extension length, the extension characters, the 32-bit payload size and the
// payload bytes. Each completed field leaves as one output transaction (tuser holds the
// section and the mismatch status, tlast marks the frame's final result). One byte is
// taken every cycle: the decode is a single pass of logic into the result register, and
// in_tready only drops while that register holds a result the sink has not yet taken.
// An accepted byte's result is registered and appears in the next cycle.
module lsb_stego_payload_deframer
  import lspd_pkg::*;
#(
  parameter int MAX_MAGIC_LEN = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] pixel_byte
  input  wire logic        in_tuser,    // [0] frame_start
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [31:0] out_tdata,   // [31:0] value
  output      logic [3:0]  out_tuser,   // [2:0] section, [3] status
  output      logic        out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam logic [3:0] MAX_MLEN = 4'(MAX_MAGIC_LEN);

  logic [15:0] header_len_r;
  logic [3:0]  magic_len_r;
  logic [63:0] magic_value_r;

  phase_t      phase_r, phase_nxt;
  logic [15:0] header_count_r, header_count_nxt;
  logic [4:0]  bit_count_r, bit_count_nxt;
  logic [31:0] shift_word_r, shift_word_nxt;
  logic [31:0] remaining_r, remaining_nxt;
  logic [3:0]  magic_index_r, magic_index_nxt;
  logic        magic_ok_r, magic_ok_nxt;

  logic        out_valid_r;
  logic [2:0]  section_r;
  logic [31:0] value_r;
  logic        status_r;
  logic        last_r;

  logic        in_acc;
  logic        bit_in;
  logic [3:0]  mlen;

  phase_t      ph_e, ph_w;
  logic [15:0] hc_e;
  logic [4:0]  bc_e, bc_w;
  logic [31:0] sw_e, sw_w;
  logic [31:0] rem_e;
  logic [3:0]  mi_e, mi_w;
  logic        ok_e;
  logic        hdr_skip;

  logic [31:0] sw_shift;
  logic [4:0]  bc_inc;
  logic        byte_done;
  logic        word_done;
  logic        magic_skip;
  logic [3:0]  mi_inc;
  logic        magic_last;
  logic [2:0]  byte_sel;
  logic [7:0]  expect_byte;
  logic        ok_upd;
  logic [31:0] rem_dec;

  logic        res_valid;
  logic [2:0]  res_section;
  logic [31:0] res_value;
  logic        res_status;
  logic        res_last;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign bit_in     = in_tdata[0];
  assign mlen       = (magic_len_r > MAX_MLEN) ? MAX_MLEN : magic_len_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = value_r;
  assign out_tuser  = {status_r, section_r};
  assign out_tlast  = last_r;

  // Restart on frame start, then fall out of the header skip when it is done.
  always_comb begin
    ph_e  = in_tuser ? PH_HEADER : phase_r;
    hc_e  = in_tuser ? 16'd0 : header_count_r;
    bc_e  = in_tuser ? 5'd0 : bit_count_r;
    sw_e  = in_tuser ? 32'd0 : shift_word_r;
    rem_e = in_tuser ? 32'd0 : remaining_r;
    mi_e  = in_tuser ? 4'd0 : magic_index_r;
    ok_e  = in_tuser ? 1'b1 : magic_ok_r;

    hdr_skip = (ph_e == PH_HEADER) && (hc_e < header_len_r);
    if ((ph_e == PH_HEADER) && !hdr_skip) begin
      ph_w = PH_MAGIC;
      bc_w = 5'd0;
      sw_w = 32'd0;
      mi_w = 4'd0;
    end else begin
      ph_w = ph_e;
      bc_w = bc_e;
      sw_w = sw_e;
      mi_w = mi_e;
    end

    sw_shift    = {sw_w[30:0], bit_in};
    bc_inc      = bc_w + 5'd1;
    byte_done   = bc_inc >= 5'd8;
    word_done   = bc_inc == 5'd0;
    magic_skip  = mi_w >= mlen;
    mi_inc      = mi_w + 4'd1;
    magic_last  = mi_inc >= mlen;
    byte_sel    = 3'(mlen - 4'd1 - mi_w);
    expect_byte = magic_value_r[{byte_sel, 3'b000} +: 8];
    ok_upd      = ok_e && (sw_shift[7:0] == expect_byte);
    rem_dec     = rem_e - 32'd1;
  end

  // Next state.
  always_comb begin
    phase_nxt        = ph_w;
    header_count_nxt = hc_e;
    bit_count_nxt    = bc_inc;
    shift_word_nxt   = sw_shift;
    remaining_nxt    = rem_e;
    magic_index_nxt  = mi_w;
    magic_ok_nxt     = ok_e;
    unique case (ph_w)
      PH_HEADER: begin
        header_count_nxt = hc_e + 16'd1;
        bit_count_nxt    = bc_w;
        shift_word_nxt   = sw_w;
      end
      PH_MAGIC: begin
        if (magic_skip) begin
          phase_nxt      = PH_EXTLEN;
          bit_count_nxt  = 5'd1;
          shift_word_nxt = {31'd0, bit_in};
        end else if (byte_done) begin
          magic_ok_nxt    = ok_upd;
          magic_index_nxt = mi_inc;
          bit_count_nxt   = 5'd0;
          shift_word_nxt  = 32'd0;
          if (magic_last) begin
            phase_nxt = ok_upd ? PH_EXTLEN : PH_IDLE;
          end
        end
      end
      PH_EXTLEN: begin
        if (word_done) begin
          shift_word_nxt = 32'd0;
          remaining_nxt  = sw_shift;
          phase_nxt      = (sw_shift == 32'd0) ? PH_SIZE : PH_EXTCHR;
        end
      end
      PH_EXTCHR: begin
        if (byte_done) begin
          bit_count_nxt  = 5'd0;
          shift_word_nxt = 32'd0;
          remaining_nxt  = rem_dec;
          if (rem_dec == 32'd0) begin
            phase_nxt = PH_SIZE;
          end
        end
      end
      PH_SIZE: begin
        if (word_done) begin
          shift_word_nxt = 32'd0;
          remaining_nxt  = sw_shift;
          phase_nxt      = (sw_shift == 32'd0) ? PH_IDLE : PH_DATA;
        end
      end
      PH_DATA: begin
        if (byte_done) begin
          bit_count_nxt  = 5'd0;
          shift_word_nxt = 32'd0;
          remaining_nxt  = rem_dec;
          if (rem_dec == 32'd0) begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_IDLE: begin
        bit_count_nxt  = bc_w;
        shift_word_nxt = sw_w;
      end
      default: begin
        bit_count_nxt  = bc_w;
        shift_word_nxt = sw_w;
      end
    endcase
  end

  // Result of this transaction.
  always_comb begin
    res_valid   = 1'b0;
    res_section = SEC_MAGIC;
    res_value   = 32'd0;
    res_status  = 1'b0;
    res_last    = 1'b0;
    unique case (ph_w)
      PH_MAGIC: begin
        if (magic_skip) begin
          res_valid = 1'b1;
        end else if (byte_done && magic_last) begin
          res_valid  = 1'b1;
          res_status = !ok_upd;
          res_last   = !ok_upd;
        end
      end
      PH_EXTLEN: begin
        res_valid   = word_done;
        res_section = SEC_EXTLEN;
        res_value   = sw_shift;
      end
      PH_EXTCHR: begin
        res_valid   = byte_done;
        res_section = SEC_EXTCHR;
        res_value   = {24'd0, sw_shift[7:0]};
      end
      PH_SIZE: begin
        res_valid   = word_done;
        res_section = SEC_SIZE;
        res_value   = sw_shift;
        res_last    = sw_shift == 32'd0;
      end
      PH_DATA: begin
        res_valid   = byte_done;
        res_section = SEC_PAYLOAD;
        res_value   = {24'd0, sw_shift[7:0]};
        res_last    = rem_dec == 32'd0;
      end
      PH_HEADER, PH_IDLE: begin
        res_valid = 1'b0;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_len_r  <= HEADER_LEN_RST;
      magic_len_r   <= MAGIC_LEN_RST;
      magic_value_r <= MAGIC_VALUE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADER_LEN:  header_len_r  <= cfg_data[15:0];
        CFG_MAGIC_LEN:   magic_len_r   <= cfg_data[3:0];
        CFG_MAGIC_VALUE: magic_value_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      header_count_r <= 16'd0;
      bit_count_r    <= 5'd0;
      shift_word_r   <= 32'd0;
      remaining_r    <= 32'd0;
      magic_index_r  <= 4'd0;
      magic_ok_r     <= 1'b1;
    end else if (in_acc) begin
      phase_r        <= phase_nxt;
      header_count_r <= header_count_nxt;
      bit_count_r    <= bit_count_nxt;
      shift_word_r   <= shift_word_nxt;
      remaining_r    <= remaining_nxt;
      magic_index_r  <= magic_index_nxt;
      magic_ok_r     <= magic_ok_nxt;
    end
  end

  // Hold the result until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      section_r <= res_section;
      value_r   <= res_value;
      status_r  <= res_status;
      last_r    <= res_last;
    end
  end

  `LSPD_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !out_valid_r, in_tready)
  `LSPD_ASSERT_SAME(a_mismatch_ends_frame, clk, rst_n, out_valid_r && status_r,
                    last_r && (section_r == SEC_MAGIC))
  `LSPD_ASSERT_NEXT(a_mismatch_goes_idle, clk, rst_n, in_acc && res_valid && res_status,
                    phase_r == PH_IDLE)
  `LSPD_ASSERT_SAME(a_magic_index_bound, clk, rst_n, phase_r == PH_MAGIC,
                    magic_index_r <= MAX_MLEN)
  `LSPD_ASSERT_SAME(a_byte_bit_count, clk, rst_n,
                    (phase_r == PH_MAGIC) || (phase_r == PH_EXTCHR) || (phase_r == PH_DATA),
                    bit_count_r < 5'd8)

endmodule

`default_nettype wire

// ===== dv/lsb_stego_payload_deframer_tb.sv =====
`timescale 1ns / 1ps

module lsb_stego_payload_deframer_tb;
  import lspd_pkg::*;

  localparam int MAX_MAGIC_LEN = 8;
  localparam logic ST_OK = 1'b0;
  localparam logic ST_MISMATCH = 1'b1;

  typedef struct packed {
    logic [2:0]  section;
    logic [31:0] value;
    logic        status;
    logic        last;
  } decoded_t;

  typedef enum logic {ROW_CFG, ROW_BITS} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  cfg_idx;
    logic [63:0] cfg_val;
    logic        start;
    logic [15:0] hdr;
    logic [6:0]  nbits;
    logic [63:0] bits;
    logic        typed;
    decoded_t    want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] pixel_byte
  logic        in_tuser;    // [0] frame_start
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // [31:0] value
  logic [3:0]  out_tuser;   // [2:0] section, [3] status
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  // predictor state and its copy of the registers
  phase_t      ph;
  logic [15:0] hdr_cnt;
  logic [4:0]  bit_cnt;
  logic [31:0] shreg;
  logic [31:0] remain;
  logic [3:0]  mag_idx;
  logic        mag_ok;
  logic [15:0] cfg_hdr_len;
  logic [3:0]  cfg_mag_len;
  logic [63:0] cfg_mag_val;

  decoded_t    result_q[$];
  decoded_t    exp_res;
  logic [7:0]  frame_bytes[$];
  dir_row_t    dir_rows[$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int n_items = 0;
  int n_frames = 0;
  int n_results = 0;
  int n_mismatch_seen = 0;
  int n_errors = 0;

  lsb_stego_payload_deframer #(
    .MAX_MAGIC_LEN(MAX_MAGIC_LEN)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic decoded_t mk_result(input logic [2:0] sec, input logic [31:0] val,
                                         input logic st, input logic lst);
    decoded_t r;
    r.section = sec;
    r.value = val;
    r.status = st;
    r.last = lst;
    return r;
  endfunction

  function automatic void parser_restart();
    ph = PH_HEADER;
    hdr_cnt = '0;
    bit_cnt = '0;
    shreg = '0;
    remain = '0;
    mag_idx = '0;
    mag_ok = 1'b1;
  endfunction

  function automatic logic shift_in(input logic b, input int width);
    shreg = {shreg[30:0], b};
    bit_cnt = bit_cnt + 5'd1;
    if (width == 32) return bit_cnt == 5'd0;
    if (bit_cnt >= width) begin
      bit_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void decode_byte(input logic [7:0] pix, input logic start,
                                      output logic got, output decoded_t res);
    logic [3:0]  mlen;
    logic [31:0] v;
    int          sh;
    got = 1'b0;
    res = '0;
    mlen = (cfg_mag_len > 4'(MAX_MAGIC_LEN)) ? 4'(MAX_MAGIC_LEN) : cfg_mag_len;
    if (start) parser_restart();
    if (ph == PH_HEADER) begin
      if (hdr_cnt < cfg_hdr_len) begin
        hdr_cnt = hdr_cnt + 16'd1;
        return;
      end
      ph = PH_MAGIC;
      mag_idx = '0;
      bit_cnt = '0;
      shreg = '0;
    end
    case (ph)
      PH_MAGIC: begin
        if (mag_idx >= mlen) begin
          ph = PH_EXTLEN;
          bit_cnt = '0;
          shreg = '0;
          void'(shift_in(pix[0], 32));
          got = 1'b1;
          res = mk_result(SEC_MAGIC, '0, ST_OK, 1'b0);
        end else if (shift_in(pix[0], 8)) begin
          sh = 8 * (int'(mlen) - 1 - int'(mag_idx));
          if (shreg[7:0] != cfg_mag_val[sh +: 8]) mag_ok = 1'b0;
          mag_idx = mag_idx + 4'd1;
          shreg = '0;
          if (mag_idx >= mlen) begin
            got = 1'b1;
            if (mag_ok) begin
              ph = PH_EXTLEN;
              res = mk_result(SEC_MAGIC, '0, ST_OK, 1'b0);
            end else begin
              ph = PH_IDLE;
              res = mk_result(SEC_MAGIC, '0, ST_MISMATCH, 1'b1);
            end
          end
        end
      end
      PH_EXTLEN: begin
        if (shift_in(pix[0], 32)) begin
          v = shreg;
          shreg = '0;
          remain = v;
          ph = (v == 0) ? PH_SIZE : PH_EXTCHR;
          got = 1'b1;
          res = mk_result(SEC_EXTLEN, v, ST_OK, 1'b0);
        end
      end
      PH_EXTCHR: begin
        if (shift_in(pix[0], 8)) begin
          v = {24'd0, shreg[7:0]};
          shreg = '0;
          remain = remain - 32'd1;
          if (remain == 0) ph = PH_SIZE;
          got = 1'b1;
          res = mk_result(SEC_EXTCHR, v, ST_OK, 1'b0);
        end
      end
      PH_SIZE: begin
        if (shift_in(pix[0], 32)) begin
          v = shreg;
          shreg = '0;
          remain = v;
          got = 1'b1;
          if (v == 0) begin
            ph = PH_IDLE;
            res = mk_result(SEC_SIZE, v, ST_OK, 1'b1);
          end else begin
            ph = PH_DATA;
            res = mk_result(SEC_SIZE, v, ST_OK, 1'b0);
          end
        end
      end
      PH_DATA: begin
        if (shift_in(pix[0], 8)) begin
          v = {24'd0, shreg[7:0]};
          shreg = '0;
          remain = remain - 32'd1;
          got = 1'b1;
          if (remain == 0) begin
            ph = PH_IDLE;
            res = mk_result(SEC_PAYLOAD, v, ST_OK, 1'b1);
          end else begin
            res = mk_result(SEC_PAYLOAD, v, ST_OK, 1'b0);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] byte_with(input logic b);
    logic [7:0] p;
    p = 8'($urandom_range(0, 255));
    p[0] = b;
    return p;
  endfunction

  function automatic void push_bits(input logic [63:0] v, input int n);
    for (int j = n - 1; j >= 0; j--) frame_bytes.push_back(byte_with(v[j]));
  endfunction

  function automatic dir_row_t cfg_row(input logic [1:0] idx, input logic [63:0] val);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  function automatic dir_row_t bits_row(input logic start, input logic [15:0] hdr,
                                        input logic [6:0] nbits, input logic [63:0] bits,
                                        input logic typed, input decoded_t want);
    dir_row_t r;
    r = '0;
    r.kind = ROW_BITS;
    r.start = start;
    r.hdr = hdr;
    r.nbits = nbits;
    r.bits = bits;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] pix, input logic start, input logic typed,
                           input decoded_t want);
    logic     got;
    decoded_t res;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pix;
    in_tuser <= start;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    decode_byte(pix, start, got, res);
    if (typed) result_q.push_back(want);
    else if (got) result_q.push_back(res);
    n_items++;
  endtask

  // hold the source until every result is back, then let the block go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (result_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_HEADER_LEN:  cfg_hdr_len = val[15:0];
      CFG_MAGIC_LEN:   cfg_mag_len = val[3:0];
      CFG_MAGIC_VALUE: cfg_mag_val = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_config();
    cfg_write(CFG_HEADER_LEN, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
    cfg_write(CFG_MAGIC_LEN, $urandom_range(0, 15));
    cfg_write(CFG_MAGIC_VALUE, {$urandom, $urandom});
  endtask

  task automatic send_frame(input logic allow_break);
    int          mlen;
    int          n_ext;
    int          n_pay;
    int          cut;
    logic [7:0]  ch;
    logic [31:0] pay_size;
    frame_bytes.delete();
    mlen = (cfg_mag_len > MAX_MAGIC_LEN) ? MAX_MAGIC_LEN : cfg_mag_len;
    for (int i = 0; i < cfg_hdr_len; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < mlen; i++) begin
      ch = cfg_mag_val[8 * (mlen - 1 - i) +: 8];
      if ($urandom_range(0, 9) == 0) ch = 8'($urandom_range(0, 255));
      push_bits(ch, 8);
    end
    n_ext = $urandom_range(0, 3);
    push_bits(n_ext, 32);
    repeat (n_ext) push_bits($urandom_range(0, 255), 8);
    if ($urandom_range(0, 11) == 0) begin
      pay_size = $urandom;
      n_pay = $urandom_range(0, 3);
    end else begin
      n_pay = $urandom_range(0, 6);
      pay_size = n_pay;
    end
    push_bits(pay_size, 32);
    repeat (n_pay) push_bits($urandom_range(0, 255), 8);
    repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    if (allow_break && frame_bytes.size() > 1 && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == 0, 1'b0, '0);
    n_frames++;
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 40))
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, 1'b0, '0);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (out_tuser[3]) n_mismatch_seen++;
      if (result_q.size() == 0) begin
        $error("result without expectation: section %0d value 0x%08h",
               out_tuser[2:0], out_tdata);
        n_errors++;
      end else begin
        exp_res = result_q.pop_front();
        if (out_tuser[2:0] !== exp_res.section) begin
          $error("section mismatch: expected %0d, actual %0d", exp_res.section,
                 out_tuser[2:0]);
          n_errors++;
        end
        if (out_tdata !== exp_res.value) begin
          $error("value mismatch: expected 0x%08h, actual 0x%08h", exp_res.value, out_tdata);
          n_errors++;
        end
        if (out_tuser[3] !== exp_res.status) begin
          $error("status mismatch: expected %0d, actual %0d", exp_res.status, out_tuser[3]);
          n_errors++;
        end
        if (out_tlast !== exp_res.last) begin
          $error("last mismatch: expected %0d, actual %0d", exp_res.last, out_tlast);
          n_errors++;
        end
      end
    end
  end

  initial begin
    dir_row_t row;
    int       mode_start;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_HEADER_LEN;
    cfg_data = '0;
    cfg_hdr_len = HEADER_LEN_RST;
    cfg_mag_len = MAGIC_LEN_RST;
    cfg_mag_val = MAGIC_VALUE_RST;
    parser_restart();

    // reset defaults, no frame start yet
    dir_rows.push_back(bits_row(1'b0, 16'd54, 7'd16, 64'h2322, 1'b1,
                                mk_result(SEC_MAGIC, 0, ST_OK, 1'b0)));
    dir_rows.push_back(bits_row(1'b0, 0, 7'd32, 0, 1'b1, mk_result(SEC_EXTLEN, 0, ST_OK, 1'b0)));
    dir_rows.push_back(bits_row(1'b0, 0, 7'd32, 0, 1'b1, mk_result(SEC_SIZE, 0, ST_OK, 1'b1)));
    // no magic, empty extension and payload, trailing bytes
    dir_rows.push_back(cfg_row(CFG_HEADER_LEN, 0));
    dir_rows.push_back(cfg_row(CFG_MAGIC_LEN, 0));
    dir_rows.push_back(bits_row(1'b1, 0, 7'd32, 0, 1'b1, mk_result(SEC_EXTLEN, 0, ST_OK, 1'b0)));
    dir_rows.push_back(bits_row(1'b0, 0, 7'd32, 0, 1'b1, mk_result(SEC_SIZE, 0, ST_OK, 1'b1)));
    dir_rows.push_back(bits_row(1'b0, 0, 7'd8, 64'hFF, 1'b0, '0));
    // full-length magic, extreme field values, restart mid-payload, mismatch
    dir_rows.push_back(cfg_row(CFG_MAGIC_VALUE, '1));
    dir_rows.push_back(cfg_row(CFG_MAGIC_LEN, 8));
    dir_rows.push_back(cfg_row(CFG_HEADER_LEN, 3));
    dir_rows.push_back(bits_row(1'b1, 3, 7'd64, '1, 1'b1, mk_result(SEC_MAGIC, 0, ST_OK, 1'b0)));
    dir_rows.push_back(bits_row(1'b0, 0, 7'd32, 2, 1'b1, mk_result(SEC_EXTLEN, 2, ST_OK, 1'b0)));
    dir_rows.push_back(bits_row(1'b0, 0, 7'd8, 0, 1'b1, mk_result(SEC_EXTCHR, 0, ST_OK, 1'b0)));
    dir_rows.push_back(bits_row(1'b0, 0, 7'd8, 64'hFF, 1'b1,
                                mk_result(SEC_EXTCHR, 32'hFF, ST_OK, 1'b0)));
    dir_rows.push_back(bits_row(1'b0, 0, 7'd32, 64'hFFFF_FFFF, 1'b1,
                                mk_result(SEC_SIZE, 32'hFFFF_FFFF, ST_OK, 1'b0)));
    dir_rows.push_back(bits_row(1'b0, 0, 7'd8, 64'hA5, 1'b1,
                                mk_result(SEC_PAYLOAD, 32'hA5, ST_OK, 1'b0)));
    dir_rows.push_back(bits_row(1'b1, 3, 7'd64, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1,
                                mk_result(SEC_MAGIC, 0, ST_MISMATCH, 1'b1)));
    dir_rows.push_back(bits_row(1'b0, 0, 7'd32, 64'hDEAD_BEEF, 1'b0, '0));
    // magic length above the maximum saturates
    dir_rows.push_back(cfg_row(CFG_MAGIC_LEN, 15));
    dir_rows.push_back(cfg_row(CFG_MAGIC_VALUE, 64'h0123_4567_89AB_CDEF));
    dir_rows.push_back(cfg_row(CFG_HEADER_LEN, 0));
    dir_rows.push_back(bits_row(1'b1, 0, 7'd64, 64'h0123_4567_89AB_CDEF, 1'b1,
                                mk_result(SEC_MAGIC, 0, ST_OK, 1'b0)));
    dir_rows.push_back(bits_row(1'b0, 0, 7'd32, 0, 1'b1, mk_result(SEC_EXTLEN, 0, ST_OK, 1'b0)));
    dir_rows.push_back(bits_row(1'b0, 0, 7'd32, 1, 1'b1, mk_result(SEC_SIZE, 1, ST_OK, 1'b0)));
    dir_rows.push_back(bits_row(1'b0, 0, 7'd8, 64'h3C, 1'b1,
                                mk_result(SEC_PAYLOAD, 32'h3C, ST_OK, 1'b1)));
    // magic length lowered after the first character
    dir_rows.push_back(cfg_row(CFG_MAGIC_VALUE, MAGIC_VALUE_RST));
    dir_rows.push_back(cfg_row(CFG_MAGIC_LEN, 2));
    dir_rows.push_back(bits_row(1'b1, 0, 7'd8, 64'h23, 1'b0, '0));
    dir_rows.push_back(cfg_row(CFG_MAGIC_LEN, 1));
    dir_rows.push_back(bits_row(1'b0, 0, 7'd32, 1, 1'b1, mk_result(SEC_EXTLEN, 1, ST_OK, 1'b0)));
    dir_rows.push_back(bits_row(1'b0, 0, 7'd8, 64'h7E, 1'b1,
                                mk_result(SEC_EXTCHR, 32'h7E, ST_OK, 1'b0)));
    dir_rows.push_back(bits_row(1'b0, 0, 7'd32, 0, 1'b1, mk_result(SEC_SIZE, 0, ST_OK, 1'b1)));
    // header length lowered while skipping
    dir_rows.push_back(cfg_row(CFG_HEADER_LEN, 16'hFFFF));
    dir_rows.push_back(bits_row(1'b1, 5, 7'd0, 0, 1'b0, '0));
    dir_rows.push_back(cfg_row(CFG_HEADER_LEN, 2));
    dir_rows.push_back(bits_row(1'b0, 0, 7'd8, 64'h22, 1'b1,
                                mk_result(SEC_MAGIC, 0, ST_OK, 1'b0)));
    dir_rows.push_back(bits_row(1'b0, 0, 7'd32, 0, 1'b1, mk_result(SEC_EXTLEN, 0, ST_OK, 1'b0)));
    dir_rows.push_back(bits_row(1'b0, 0, 7'd32, 0, 1'b1, mk_result(SEC_SIZE, 0, ST_OK, 1'b1)));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    src_idle_pct = 11;
    sink_stall_pct = 11;
    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      if (row.kind == ROW_CFG) begin
        settle();
        cfg_write(row.cfg_idx, row.cfg_val);
      end else begin
        for (int h = 0; h < row.hdr; h++)
          send_byte(8'($urandom_range(0, 255)), row.start && h == 0, 1'b0, '0);
        for (int j = row.nbits - 1; j >= 0; j--)
          send_byte(byte_with(row.bits[j]), row.start && row.hdr == 0 && j == row.nbits - 1,
                    row.typed && j == 0, row.want);
      end
    end

    for (int m = 0; m < 4; m++) begin
      settle();
      case (m)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 83;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 83;
        end
        default: begin
          src_idle_pct = 11;
          sink_stall_pct = 11;
        end
      endcase
      mode_start = n_items;
      while (n_items - mode_start < 250) begin
        settle();
        random_config();
        repeat (2) begin
          if ($urandom_range(0, 99) < 15) send_noise();
          else send_frame(1'b1);
        end
      end
    end

    settle();
    repeat (10) @(negedge clk);
    $display("%0d image bytes, %0d random frames, %0d results checked (%0d magic mismatches)",
             n_items, n_frames, n_results, n_mismatch_seen);
    $display("headers 0..6 plus a skip cut short from 65535, magic lengths 0..15, four stall mixes");
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/lspd_pkg.sv
hw/rtl/lsb_stego_payload_deframer.sv
dv/lsb_stego_payload_deframer_tb.sv
